>>> src/qpwg_pkg.sv
// ----------------------------------------------------------------------------
// qpwg_pkg: shared constants and types for the weighted gradient block
// Fixed-point format, register map and the result status struct.
// ----------------------------------------------------------------------------
package qpwg_pkg;

  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned IoWidth      = 32;
  localparam int unsigned AddrWidth    = 2;

  localparam logic [AddrWidth-1:0] RegStiffnessGain = 2'd0;
  localparam logic [IoWidth-1:0]   StiffnessReset   = 32'sd65536;

  // Status held with each result in the output register.
  typedef struct packed {
    logic valid;
    logic last;
    logic sing;
    logic clip;
  } qpwg_ctl_t;

endpackage

>>> src/qpwg_div.sv
// ----------------------------------------------------------------------------
// qpwg_div: pipelined restoring divider
// Computes 2^(2*FRAC_BITS) / den truncated toward zero and saturated to DATA_WIDTH,
// one quotient bit per stage, with side data carried along the stages.
// ----------------------------------------------------------------------------
module qpwg_div #(
  parameter int unsigned FRAC_BITS  = qpwg_pkg::FracBitsDef,
  parameter int unsigned DATA_WIDTH = qpwg_pkg::DataWidthDef,
  parameter int unsigned SIDE_W     = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic signed [DATA_WIDTH-1:0] den_i,
  input  logic [SIDE_W-1:0]            side_i,
  output logic                         out_valid_o,
  output logic signed [DATA_WIDTH-1:0] quo_o,
  output logic                         clip_o,
  output logic [SIDE_W-1:0]            side_o
);
  import qpwg_pkg::*;

  localparam int unsigned NumW  = 2 * FRAC_BITS + 2;
  localparam int unsigned Steps = NumW;
  localparam int unsigned RemW  = DATA_WIDTH + 1;

  logic [Steps:0]             vld_q;
  logic [Steps:0][RemW-1:0]   rem_q;
  logic [Steps:0][NumW-1:0]   quo_q;
  logic [Steps:0][DATA_WIDTH-1:0] dmag_q;
  logic [Steps:0]             neg_q;
  logic [Steps:0][SIDE_W-1:0] side_q;
  logic [Steps-1:0][RemW:0]   trial;
  logic [Steps-1:0][RemW-1:0] shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Steps-1:0], in_valid_i};
    end
  end

  always_comb begin
    for (int s = 0; s < Steps; s++) begin
      shifted[s] = {rem_q[s][RemW-2:0], quo_q[s][NumW-1]};
      trial[s]   = {1'b0, shifted[s]} - {2'b0, dmag_q[s]};
    end
  end

  // Stage 0 captures magnitude and sign; quotient register holds the dividend.
  always_ff @(posedge clk_i) begin
    rem_q[0]  <= '0;
    quo_q[0]  <= NumW'(1) << (2 * FRAC_BITS);
    dmag_q[0] <= den_i[DATA_WIDTH-1] ? DATA_WIDTH'(-den_i) : DATA_WIDTH'(den_i);
    neg_q[0]  <= den_i[DATA_WIDTH-1];
    side_q[0] <= side_i;
    for (int s = 0; s < Steps; s++) begin
      if (!trial[s][RemW]) begin
        rem_q[s+1] <= trial[s][RemW-1:0];
      end else begin
        rem_q[s+1] <= shifted[s];
      end
      quo_q[s+1]  <= {quo_q[s][NumW-2:0], ~trial[s][RemW]};
      dmag_q[s+1] <= dmag_q[s];
      neg_q[s+1]  <= neg_q[s];
      side_q[s+1] <= side_q[s];
    end
  end

  logic [NumW:0]        sq;
  logic signed [NumW:0] sv;
  logic                 big;
  always_comb begin
    sq  = {1'b0, quo_q[Steps]};
    sv  = neg_q[Steps] ? -$signed(sq) : $signed(sq);
    big = (sv > $signed((NumW+1)'({1'b0, {(DATA_WIDTH-1){1'b1}}})))
       || (sv < -$signed((NumW+1)'({1'b1, {(DATA_WIDTH-1){1'b0}}})));
  end

  assign out_valid_o = vld_q[Steps];
  assign side_o      = side_q[Steps];
  assign clip_o      = big;
  assign quo_o       = big ? (sv[NumW] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                       : {1'b0, {(DATA_WIDTH-1){1'b1}}})
                           : DATA_WIDTH'(sv);
endmodule

>>> src/quadrature_point_weighted_gradient.sv
// ----------------------------------------------------------------------------
// quadrature_point_weighted_gradient: weighted gradient at a quadrature point
// Determinant, pipelined reciprocal, inverse Jacobian, gradient and weights.
// ----------------------------------------------------------------------------
// A result reaches done_o through determinant stages 1 and 2, the one-bit-per-stage
// reciprocal pipeline and stages A to J.
// Throughput: one item per cycle; busy_o is always low.
// Reset clears every valid bit and loads stiffness_gain with 1.0.
// Results are shown for one cycle on done_o; the receiver cannot stall.
module quadrature_point_weighted_gradient #(
  parameter int unsigned FRAC_BITS  = qpwg_pkg::FracBitsDef,
  parameter int unsigned DATA_WIDTH = qpwg_pkg::DataWidthDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [qpwg_pkg::AddrWidth-1:0]       paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [qpwg_pkg::IoWidth-1:0]  jac_00_i,
  input  logic signed [qpwg_pkg::IoWidth-1:0]  jac_01_i,
  input  logic signed [qpwg_pkg::IoWidth-1:0]  jac_10_i,
  input  logic signed [qpwg_pkg::IoWidth-1:0]  jac_11_i,
  input  logic signed [qpwg_pkg::IoWidth-1:0]  disp_der_u_i,
  input  logic signed [qpwg_pkg::IoWidth-1:0]  disp_der_v_i,
  input  logic signed [qpwg_pkg::IoWidth-1:0]  forcing_value_i,
  input  logic signed [qpwg_pkg::IoWidth-1:0]  weight_u_i,
  input  logic signed [qpwg_pkg::IoWidth-1:0]  weight_v_i,
  input  logic                                 last_point_i,
  output logic                                 done_o,
  output logic signed [qpwg_pkg::IoWidth-1:0]  weighted_grad_u_o,
  output logic signed [qpwg_pkg::IoWidth-1:0]  weighted_grad_v_o,
  output logic signed [qpwg_pkg::IoWidth-1:0]  weighted_forcing_o,
  output logic                                 singular_flag_o,
  output logic                                 saturated_flag_o,
  output logic                                 last_out_o
);
  import qpwg_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned PW = 2 * DATA_WIDTH + 2;
  localparam int unsigned IW = IoWidth;
  localparam logic signed [PW-1:0] MaxP = PW'($signed({1'b0, {(DW-1){1'b1}}}));
  localparam logic signed [PW-1:0] MinP = PW'($signed({1'b1, {(DW-1){1'b0}}}));

  // Shift and clip a full-width sum back to DATA_WIDTH bits.
  function automatic logic [DW:0] shsat(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] s;
    begin
      s = x >>> FRAC_BITS;
      if (s > MaxP) shsat = {1'b1, MaxP[DW-1:0]};
      else if (s < MinP) shsat = {1'b1, MinP[DW-1:0]};
      else shsat = {1'b0, s[DW-1:0]};
    end
  endfunction

  function automatic logic signed [PW-1:0] mul(input logic signed [DW-1:0] a,
                                               input logic signed [DW-1:0] b);
    mul = PW'(a) * PW'(b);
  endfunction

  function automatic logic signed [DW-1:0] ext(input logic signed [IW-1:0] v);
    ext = DW'(v);
  endfunction

  function automatic logic [IW:0] sat_io(input logic signed [DW-1:0] v);
    logic signed [DW:0] mx, mn;
    begin
      mx = (DW+1)'($signed({1'b0, {(IW-1){1'b1}}}));
      mn = (DW+1)'($signed({1'b1, {(IW-1){1'b0}}}));
      if ((DW+1)'(v) > mx) sat_io = {1'b1, mx[IW-1:0]};
      else if ((DW+1)'(v) < mn) sat_io = {1'b1, mn[IW-1:0]};
      else sat_io = {1'b0, v[IW-1:0]};
    end
  endfunction

  // ---------------- configuration ----------------
  logic signed [IW-1:0] kappa_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kappa_q <= StiffnessReset;
    end else if (psel && penable && pwrite && pready && paddr == RegStiffnessGain) begin
      kappa_q <= pwdata;
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr == RegStiffnessGain) ? kappa_q : '0;
  assign busy_o = 1'b0;

  // Item payload carried unchanged through the divider.
  typedef struct packed {
    logic signed [DW-1:0] j00, j01, j10, j11, du, dv, frc, wu, wv, det;
    logic last, clip;
  } item_t;

  function automatic item_t set_clip(input item_t x, input logic c);
    item_t r;
    begin
      r = x;
      r.clip = c;
      set_clip = r;
    end
  endfunction

  function automatic item_t set_det(input item_t x, input logic [DW-1:0] d,
                                    input logic c);
    item_t r;
    begin
      r = x;
      r.det = d;
      r.clip = c;
      set_det = r;
    end
  endfunction

  // ---------------- stage 1: determinant products ----------------
  logic v1_q;
  item_t i1_q;
  logic signed [PW-1:0] p1a_q, p1b_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= start_i;
  end
  always_ff @(posedge clk_i) begin
    i1_q.j00 <= ext(jac_00_i); i1_q.j01 <= ext(jac_01_i);
    i1_q.j10 <= ext(jac_10_i); i1_q.j11 <= ext(jac_11_i);
    i1_q.du  <= ext(disp_der_u_i); i1_q.dv <= ext(disp_der_v_i);
    i1_q.frc <= ext(forcing_value_i);
    i1_q.wu  <= ext(weight_u_i); i1_q.wv <= ext(weight_v_i);
    i1_q.det <= '0; i1_q.clip <= 1'b0; i1_q.last <= last_point_i;
    p1a_q <= mul(ext(jac_00_i), ext(jac_11_i));
    p1b_q <= mul(ext(jac_01_i), ext(jac_10_i));
  end

  // ---------------- stage 2: determinant ----------------
  logic v2_q;
  item_t i2_q;
  logic [DW:0] det_s;
  assign det_s = shsat(p1a_q - p1b_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    i2_q <= set_det(i1_q, det_s[DW-1:0], det_s[DW]);
  end

  // ---------------- reciprocal ----------------
  logic dv_v, dv_clip;
  logic signed [DW-1:0] c_w;
  item_t i3;
  qpwg_div #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DW), .SIDE_W($bits(item_t))) u_div (
    .clk_i, .rst_ni,
    .in_valid_i(v2_q), .den_i(i2_q.det), .side_i(i2_q),
    .out_valid_o(dv_v), .quo_o(c_w), .clip_o(dv_clip), .side_o(i3)
  );

  // ---------------- stage A: inverse products, weight product ----------------
  logic va_q; item_t ia_q;
  logic signed [PW-1:0] pa00_q, pa01_q, pa10_q, pa11_q, pw_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else va_q <= dv_v;
  end
  always_ff @(posedge clk_i) begin
    ia_q <= set_clip(i3, i3.clip | (dv_clip & (i3.det != '0)));
    pa00_q <= mul(c_w, i3.j11);
    pa01_q <= -mul(c_w, i3.j01);
    pa10_q <= -mul(c_w, i3.j10);
    pa11_q <= mul(c_w, i3.j00);
    pw_q   <= mul(i3.wu, i3.wv);
  end

  // stage B: inverse entries and weight product shift/clip
  logic vb_q; item_t ib_q;
  logic signed [DW-1:0] a00_b, a01_b, a10_b, a11_b, wuv_b;
  logic [DW:0] s00, s01, s10, s11, swv;
  assign s00 = shsat(pa00_q); assign s01 = shsat(pa01_q);
  assign s10 = shsat(pa10_q); assign s11 = shsat(pa11_q);
  assign swv = shsat(pw_q);
  logic signed [DW-1:0] a00_q, a01_q, a10_q, a11_q, wuv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else vb_q <= va_q;
  end
  always_ff @(posedge clk_i) begin
    ib_q <= set_clip(ia_q, ia_q.clip | s00[DW] | s01[DW] | s10[DW] | s11[DW] | swv[DW]);
    a00_q <= s00[DW-1:0]; a01_q <= s01[DW-1:0];
    a10_q <= s10[DW-1:0]; a11_q <= s11[DW-1:0];
    wuv_q <= swv[DW-1:0];
  end
  assign a00_b = a00_q; assign a01_b = a01_q;
  assign a10_b = a10_q; assign a11_b = a11_q; assign wuv_b = wuv_q;

  // stage C: products for t and w
  logic vc_q; item_t ic_q;
  logic signed [DW-1:0] c00, c01, c10, c11;
  logic signed [PW-1:0] t0p_q, t1p_q, wp_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else vc_q <= vb_q;
  end
  always_ff @(posedge clk_i) begin
    ic_q <= ib_q;
    c00 <= a00_b; c01 <= a01_b; c10 <= a10_b; c11 <= a11_b;
    t0p_q <= mul(a00_b, ib_q.du) + mul(a10_b, ib_q.dv);
    t1p_q <= mul(a01_b, ib_q.du) + mul(a11_b, ib_q.dv);
    wp_q  <= mul(wuv_b, ib_q.det);
  end

  // stage D: t and w shift/clip
  logic vd_q; item_t id_q;
  logic signed [DW-1:0] d00, d01, d10, d11, t0_q, t1_q, w_q;
  logic [DW:0] st0, st1, sw;
  assign st0 = shsat(t0p_q); assign st1 = shsat(t1p_q); assign sw = shsat(wp_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q <= 1'b0;
    else vd_q <= vc_q;
  end
  always_ff @(posedge clk_i) begin
    id_q <= set_clip(ic_q, ic_q.clip | st0[DW] | st1[DW] | sw[DW]);
    d00 <= c00; d01 <= c01; d10 <= c10; d11 <= c11;
    t0_q <= st0[DW-1:0]; t1_q <= st1[DW-1:0]; w_q <= sw[DW-1:0];
  end

  // stage E: kappa products
  logic ve_q; item_t ie_q;
  logic signed [DW-1:0] e00, e01, e10, e11, we_q;
  logic signed [PW-1:0] q0p_q, q1p_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ve_q <= 1'b0;
    else ve_q <= vd_q;
  end
  always_ff @(posedge clk_i) begin
    ie_q <= id_q;
    e00 <= d00; e01 <= d01; e10 <= d10; e11 <= d11; we_q <= w_q;
    q0p_q <= mul(ext(kappa_q), t0_q);
    q1p_q <= mul(ext(kappa_q), t1_q);
  end

  // stage F: q shift/clip
  logic vf_q; item_t if_q;
  logic signed [DW-1:0] f00, f01, f10, f11, wf_q, q0_q, q1_q;
  logic [DW:0] sq0, sq1;
  assign sq0 = shsat(q0p_q); assign sq1 = shsat(q1p_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vf_q <= 1'b0;
    else vf_q <= ve_q;
  end
  always_ff @(posedge clk_i) begin
    if_q <= set_clip(ie_q, ie_q.clip | sq0[DW] | sq1[DW]);
    f00 <= e00; f01 <= e01; f10 <= e10; f11 <= e11; wf_q <= we_q;
    q0_q <= sq0[DW-1:0]; q1_q <= sq1[DW-1:0];
  end

  // stage G: g products (negated sums)
  logic vg_q; item_t ig_q;
  logic signed [DW-1:0] wg_q;
  logic signed [PW-1:0] g0p_q, g1p_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vg_q <= 1'b0;
    else vg_q <= vf_q;
  end
  always_ff @(posedge clk_i) begin
    ig_q <= if_q; wg_q <= wf_q;
    g0p_q <= -(mul(f00, q0_q) + mul(f01, q1_q));
    g1p_q <= -(mul(f10, q0_q) + mul(f11, q1_q));
  end

  // stage H: g shift/clip
  logic vh_q; item_t ih_q;
  logic signed [DW-1:0] wh_q, g0_q, g1_q;
  logic [DW:0] sg0, sg1;
  assign sg0 = shsat(g0p_q); assign sg1 = shsat(g1p_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vh_q <= 1'b0;
    else vh_q <= vg_q;
  end
  always_ff @(posedge clk_i) begin
    ih_q <= set_clip(ig_q, ig_q.clip | sg0[DW] | sg1[DW]);
    wh_q <= wg_q; g0_q <= sg0[DW-1:0]; g1_q <= sg1[DW-1:0];
  end

  // stage I: weighted products
  logic vi_q; item_t ii_q;
  logic signed [PW-1:0] r0p_q, r1p_q, r2p_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vi_q <= 1'b0;
    else vi_q <= vh_q;
  end
  always_ff @(posedge clk_i) begin
    ii_q <= ih_q;
    r0p_q <= mul(g0_q, wh_q);
    r1p_q <= mul(g1_q, wh_q);
    r2p_q <= mul(ih_q.frc, wh_q);
  end

  // stage J: final clip and output register
  logic [DW:0] sr0, sr1, sr2;
  logic [IW:0] o0, o1, o2;
  logic sing;
  assign sr0 = shsat(r0p_q); assign sr1 = shsat(r1p_q); assign sr2 = shsat(r2p_q);
  assign o0 = sat_io(sr0[DW-1:0]);
  assign o1 = sat_io(sr1[DW-1:0]);
  assign o2 = sat_io(sr2[DW-1:0]);
  assign sing = (ii_q.det == '0);

  qpwg_ctl_t ctl_q;
  logic signed [IW-1:0] r0_q, r1_q, r2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ctl_q <= '0;
    else begin
      ctl_q.valid <= vi_q;
      ctl_q.last  <= ii_q.last;
      ctl_q.sing  <= sing;
      ctl_q.clip  <= !sing && (ii_q.clip | sr0[DW] | sr1[DW] | sr2[DW]
                               | o0[IW] | o1[IW] | o2[IW]);
    end
  end
  always_ff @(posedge clk_i) begin
    r0_q <= sing ? '0 : o0[IW-1:0];
    r1_q <= sing ? '0 : o1[IW-1:0];
    r2_q <= sing ? '0 : o2[IW-1:0];
  end

  assign done_o             = ctl_q.valid;
  assign weighted_grad_u_o  = r0_q;
  assign weighted_grad_v_o  = r1_q;
  assign weighted_forcing_o = r2_q;
  assign singular_flag_o    = ctl_q.sing;
  assign saturated_flag_o   = ctl_q.clip;
  assign last_out_o         = ctl_q.last;

  // A singular result carries zero data and no clip.
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && singular_flag_o |-> weighted_grad_u_o == '0 && weighted_grad_v_o == '0
      && weighted_forcing_o == '0 && !saturated_flag_o)
    else $error("singular result not cleared");
  // Checks that the reciprocal pipeline invents no items; it drops none by construction.
  a_div_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v |-> $past(v2_q, 2 * FRAC_BITS + 3))
    else $error("divider valid mismatch");
  // The output strobe repeats the stage I valid in the following cycle.
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(vi_q))
    else $error("done strobe misaligned");
endmodule
